>>> design/dqte_pkg.sv
// ============================================================================
// dqte_pkg
// Types and constants shared by the DNS question / answer TTL extractor.
// ============================================================================
`default_nettype none

package dqte_pkg;

    localparam int HEADER_BYTES = 12;
    localparam int AC_HI_POS    = 6;
    localparam int AC_LO_POS    = 7;
    localparam int FIFO_DEPTH   = 2;

    localparam logic [7:0]  PTR_MASK     = 8'hC0;
    localparam logic [31:0] DEFAULT_TTL  = 32'd60;
    localparam logic [3:0]  QTAIL_BYTES  = 4'd4;
    localparam logic [3:0]  TTL_FIRST    = 4'd4;
    localparam logic [3:0]  AFIXED_BYTES = 4'd8;

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_QNAME    = 3'd1,
        PH_QTAIL    = 3'd2,
        PH_AFIRST   = 3'd3,
        PH_ALABELS  = 3'd4,
        PH_AFIXED   = 3'd5,
        PH_TTL_DONE = 3'd6,
        PH_IDLE     = 3'd7
    } t_phase;

    // One classified byte as it travels from the front to the parser.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       consume;   // position below the message limit
        logic       ac_hi;     // answer count, high byte
        logic       ac_lo;     // answer count, low byte
        logic       hdr_end;   // final header byte
    } t_item;

endpackage

`default_nettype wire

>>> design/dqte_front.sv
// ============================================================================
// dqte_front
// Byte front end: counts message position and tags each beat for the parser.
// ============================================================================
`default_nettype none

module dqte_front
    import dqte_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = 4096
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  wire logic       i_s_tlast,   // last_byte
    input  wire logic       i_q_ready,
    output logic            o_push,
    output t_item           o_item
);

    localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_MESSAGE_BYTES);
    localparam logic [POS_W-1:0] POS_HEND = POS_W'(HEADER_BYTES - 1);
    localparam logic [POS_W-1:0] POS_ACHI = POS_W'(AC_HI_POS);
    localparam logic [POS_W-1:0] POS_ACLO = POS_W'(AC_LO_POS);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             w_consume;

    assign o_s_tready = i_q_ready;
    assign o_push     = i_s_tvalid && i_q_ready;
    assign w_consume  = (r_pos < POS_MAX);

    always_comb begin
        o_item.data    = i_s_tdata;
        o_item.last    = i_s_tlast;
        o_item.consume = w_consume;
        o_item.ac_hi   = (r_pos == POS_ACHI);
        o_item.ac_lo   = (r_pos == POS_ACLO);
        o_item.hdr_end = (r_pos == POS_HEND);
    end

    // Saturate at the limit, restart on the final byte.
    always_comb begin
        n_pos = r_pos;
        if (o_push) begin
            if (i_s_tlast) begin
                n_pos = '0;
            end else if (w_consume) begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

`default_nettype wire

>>> design/dqte_fifo.sv
// ============================================================================
// dqte_fifo
// Short queue of classified bytes between the front end and the parser.
// ============================================================================
`default_nettype none

module dqte_fifo
    import dqte_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_ready,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_item      o_item
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_item            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_ready = (r_cnt != CNT_W'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/dqte_parse.sv
// ============================================================================
// dqte_parse
// Message parser: walks header, question name and first answer, and holds
// the result beat in an output register.
// ============================================================================
`default_nettype none

module dqte_parse
    import dqte_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_item       i_item,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [63:0]      o_m_tdata,  // [15:0] query_type, [31:16] query_class,
                                         // [63:32] answer_ttl
    output logic [1:0]       o_m_tuser   // [0] question_valid, [1] ttl_found
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_skip,  n_skip;
    logic [15:0] r_ac,    n_ac;
    logic [31:0] r_tc,    n_tc;
    logic [3:0]  r_fbi,   n_fbi;
    logic [31:0] r_ttl,   n_ttl;
    logic        r_qdone, n_qdone;

    logic        r_out_valid;
    logic [63:0] r_out_data;
    logic [1:0]  r_out_user;
    logic [63:0] w_res_data;
    logic [1:0]  w_res_user;
    logic [7:0]  w_b;
    logic [3:0]  w_fbi_inc;
    logic        w_ptr;

    assign o_pop     = i_valid && (!r_out_valid || i_m_tready);
    assign w_b       = i_item.data;
    assign w_ptr     = ((w_b & PTR_MASK) == PTR_MASK);
    assign w_fbi_inc = r_fbi + 4'd1;

    // Next parse state for one consumed byte.
    always_comb begin
        n_phase = r_phase;
        n_skip  = r_skip;
        n_ac    = r_ac;
        n_tc    = r_tc;
        n_fbi   = r_fbi;
        n_ttl   = r_ttl;
        n_qdone = r_qdone;
        if (i_item.consume) begin
            if (r_phase == PH_HEADER) begin
                if (i_item.ac_hi) begin
                    n_ac[15:8] = w_b;
                end
                if (i_item.ac_lo) begin
                    n_ac[7:0] = w_b;
                end
                if (i_item.hdr_end) begin
                    n_phase = PH_QNAME;
                end
            end else if (r_phase == PH_TTL_DONE || r_phase == PH_IDLE) begin
                n_phase = r_phase;
            end else if (r_skip != 8'd0) begin
                n_skip = r_skip - 8'd1;
            end else begin
                case (r_phase)
                    PH_QNAME: begin
                        if (w_b == 8'd0) begin
                            n_phase = PH_QTAIL;
                        end else if (w_ptr) begin
                            n_skip  = 8'd1;
                            n_phase = PH_QTAIL;
                        end else begin
                            n_skip = w_b;
                        end
                        n_fbi = '0;
                    end
                    PH_QTAIL: begin
                        n_tc  = {r_tc[23:0], w_b};
                        n_fbi = w_fbi_inc;
                        if (w_fbi_inc >= QTAIL_BYTES) begin
                            n_qdone = 1'b1;
                            n_fbi   = '0;
                            n_phase = (r_ac != 16'd0) ? PH_AFIRST : PH_IDLE;
                        end
                    end
                    PH_AFIRST: begin
                        if (w_ptr) begin
                            n_skip  = 8'd1;
                            n_phase = PH_AFIXED;
                        end else if (w_b == 8'd0) begin
                            n_phase = PH_AFIXED;
                        end else begin
                            n_skip  = w_b;
                            n_phase = PH_ALABELS;
                        end
                        n_fbi = '0;
                    end
                    PH_ALABELS: begin
                        if (w_b == 8'd0) begin
                            n_phase = PH_AFIXED;
                        end else begin
                            n_skip = w_b;
                        end
                        n_fbi = '0;
                    end
                    PH_AFIXED: begin
                        if (r_fbi >= TTL_FIRST) begin
                            n_ttl = {r_ttl[23:0], w_b};
                        end
                        n_fbi = w_fbi_inc;
                        if (w_fbi_inc >= AFIXED_BYTES) begin
                            n_phase = PH_TTL_DONE;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    // Result beat built from the state after the final byte.
    always_comb begin
        w_res_user[0]      = n_qdone;
        w_res_user[1]      = (n_phase == PH_TTL_DONE);
        w_res_data[15:0]   = n_qdone ? n_tc[31:16] : 16'd0;
        w_res_data[31:16]  = n_qdone ? n_tc[15:0]  : 16'd0;
        w_res_data[63:32]  = (n_phase == PH_TTL_DONE) ? n_ttl : DEFAULT_TTL;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_skip  <= '0;
            r_ac    <= '0;
            r_tc    <= '0;
            r_fbi   <= '0;
            r_ttl   <= '0;
            r_qdone <= 1'b0;
        end else if (o_pop) begin
            if (i_item.last) begin
                r_phase <= PH_HEADER;
                r_skip  <= '0;
                r_ac    <= '0;
                r_tc    <= '0;
                r_fbi   <= '0;
                r_ttl   <= '0;
                r_qdone <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_skip  <= n_skip;
                r_ac    <= n_ac;
                r_tc    <= n_tc;
                r_fbi   <= n_fbi;
                r_ttl   <= n_ttl;
                r_qdone <= n_qdone;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_item.last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.last) begin
            r_out_data <= w_res_data;
            r_out_user <= w_res_user;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

`default_nettype wire

>>> design/dns_question_ttl_extract.sv
// ============================================================================
// dns_question_ttl_extract
// Parses a DNS message byte stream for question type/class and first TTL.
// ============================================================================
//  channel  dir  beat contents
//  s_axis   in   tdata[7:0] message byte, tlast on final byte
//  m_axis   out  tdata type/class/TTL, tuser {ttl_found, question_valid}
//
//  One byte per cycle sustained while m_axis is not stalled. An accepted
//  byte is written into the two-entry queue and updates the parser when
//  popped; the result beat is registered when the final byte is popped.
//  Bytes at or past MAX_MESSAGE_BYTES are skipped.
//  Synchronous active-low reset returns the parser to the header phase.
//  A stalled result register backs up the queue, then s_axis tready.
// ============================================================================
`default_nettype none

module dns_question_ttl_extract
    import dqte_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  wire logic        s_axis_tlast,  // last_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // [15:0] query_type, [31:16] query_class,
                                            // [63:32] answer_ttl
    output logic [1:0]       m_axis_tuser   // [0] question_valid, [1] ttl_found
);

    logic  w_push;
    logic  w_q_ready;
    logic  w_q_valid;
    logic  w_pop;
    t_item w_in_item;
    t_item w_q_item;

    dqte_front #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tlast  (s_axis_tlast),
        .i_q_ready  (w_q_ready),
        .o_push     (w_push),
        .o_item     (w_in_item)
    );

    dqte_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    dqte_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .i_item     (w_q_item),
        .o_pop      (w_pop),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser)
    );

`ifndef SYNTH
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("parser popped an empty queue");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_q_ready)
        else $error("front pushed into a full queue");

    a_result_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_q_item.last && m_axis_tvalid) |-> m_axis_tready)
        else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire
